// ----- rtl/efc_pkg.sv -----
`timescale 1ns / 1ps

package efc_pkg;

  // Frame layout
  localparam int HDR_BYTES     = 11;
  localparam int CRC_HDR_BYTES = 7;
  localparam int COUNT_W       = 17;
  localparam int MAX_PAYLOAD   = 512;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Header byte positions
  localparam int POS_ID_HI    = 0;
  localparam int POS_ID_LO    = 1;
  localparam int POS_SEQ_HI   = 2;
  localparam int POS_SEQ_LO   = 3;
  localparam int POS_ALIVE    = 4;
  localparam int POS_LEN_HI   = 5;
  localparam int POS_LEN_LO   = 6;
  localparam int POS_CRC_B3   = 7;
  localparam int POS_CRC_B2   = 8;
  localparam int POS_CRC_B1   = 9;
  localparam int POS_CRC_B0   = 10;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LEN   = 2'd2,
    ST_CRC   = 2'd3
  } status_t;

  // Advance the CRC by one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/efc_in_if.sv -----
`timescale 1ns / 1ps

interface efc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/efc_out_if.sv -----
`timescale 1ns / 1ps

interface efc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_done;
  logic [1:0]  status;
  logic [15:0] data_id;
  logic [15:0] sequence_number;
  logic [7:0]  alive_count;
  logic [15:0] payload_length;
  logic [31:0] received_crc;

  modport source (
    output valid, output payload_byte, output payload_valid, output frame_done,
    output status, output data_id, output sequence_number, output alive_count,
    output payload_length, output received_crc, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_valid, input frame_done,
    input status, input data_id, input sequence_number, input alive_count,
    input payload_length, input received_crc, output ready
  );
endinterface

// ----- rtl/e2e_frame_checker_crc32.sv -----
`timescale 1ns / 1ps
// An accepted item passes through the input register and then the result register, where
// its result is held until taken.
// Throughput: one item per cycle; the byte-wide CRC update and header capture sit
// between the input register and the result register. A stalled result stalls the input.
// Reset: synchronous active-high rst empties both registers, zeroes the byte count and
// header, and sets the CRC to all ones. The byte count, header and CRC clear the same way after every final byte.
module e2e_frame_checker_crc32 (
  input  logic          clk,
  input  logic          rst,
  efc_in_if.sink        frame,
  efc_out_if.source     result
);
  import efc_pkg::*;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;

  // Frame state
  logic [COUNT_W-1:0] byte_count;
  logic [31:0]        crc_reg;
  logic [7:0]         hdr [HDR_BYTES];

  // Result register
  logic        out_valid;
  logic [7:0]  out_payload_byte;
  logic        out_payload_valid;
  logic        out_frame_done;
  status_t     out_status;
  logic [15:0] out_data_id;
  logic [15:0] out_sequence;
  logic [7:0]  out_alive;
  logic [15:0] out_length;
  logic [31:0] out_crc;

  logic advance;
  logic in_accept;

  assign advance     = !out_valid || result.ready;
  assign frame.ready = !s1_valid || advance;
  assign in_accept   = frame.valid && frame.ready;

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
    if (in_accept) begin
      s1_data <= frame.data_byte;
      s1_last <= frame.last_byte;
    end
  end

  // Work out the next state and the result for the item in the input register
  logic               is_payload;
  logic               in_crc_span;
  logic [COUNT_W-1:0] count_next;
  logic [31:0]        crc_next;
  logic [7:0]         hdr_next [HDR_BYTES];
  logic [15:0]        f_id;
  logic [15:0]        f_seq;
  logic [7:0]         f_alive;
  logic [15:0]        f_len;
  logic [31:0]        f_crc;
  logic [COUNT_W-1:0] expected_count;
  status_t            status_next;

  always_comb begin
    is_payload  = byte_count >= COUNT_W'(HDR_BYTES);
    in_crc_span = (byte_count < COUNT_W'(CRC_HDR_BYTES)) || is_payload;
    count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_W'(1);
    crc_next    = in_crc_span ? crc_byte(crc_reg, s1_data) : crc_reg;

    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_next[i] = (byte_count == COUNT_W'(i)) ? s1_data : hdr[i];
    end

    f_id    = {hdr_next[POS_ID_HI], hdr_next[POS_ID_LO]};
    f_seq   = {hdr_next[POS_SEQ_HI], hdr_next[POS_SEQ_LO]};
    f_alive = hdr_next[POS_ALIVE];
    f_len   = {hdr_next[POS_LEN_HI], hdr_next[POS_LEN_LO]};
    f_crc   = {hdr_next[POS_CRC_B3], hdr_next[POS_CRC_B2],
               hdr_next[POS_CRC_B1], hdr_next[POS_CRC_B0]};

    expected_count = {1'b0, f_len} + COUNT_W'(HDR_BYTES);

    if (count_next < COUNT_W'(HDR_BYTES)) begin
      status_next = ST_SHORT;
    end else if (count_next != expected_count) begin
      status_next = ST_LEN;
    end else if (f_len > 16'(MAX_PAYLOAD)) begin
      status_next = ST_SHORT;
    end else if ((crc_next ^ CRC_ONES) != f_crc) begin
      status_next = ST_CRC;
    end else begin
      status_next = ST_OK;
    end
  end

  // Update the frame state; clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc_reg    <= CRC_ONES;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr[i] <= '0;
      end
    end else if (s1_valid && advance) begin
      if (s1_last) begin
        byte_count <= '0;
        crc_reg    <= CRC_ONES;
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr[i] <= '0;
        end
      end else begin
        byte_count <= count_next;
        crc_reg    <= crc_next;
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr[i] <= hdr_next[i];
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && advance) begin
      out_payload_byte  <= is_payload ? s1_data : 8'd0;
      out_payload_valid <= is_payload;
      out_frame_done    <= s1_last;
      out_status        <= s1_last ? status_next : ST_OK;
      out_data_id       <= s1_last ? f_id : 16'd0;
      out_sequence      <= s1_last ? f_seq : 16'd0;
      out_alive         <= s1_last ? f_alive : 8'd0;
      out_length        <= s1_last ? f_len : 16'd0;
      out_crc           <= s1_last ? f_crc : 32'd0;
    end
  end

  assign result.valid           = out_valid;
  assign result.payload_byte    = out_payload_byte;
  assign result.payload_valid   = out_payload_valid;
  assign result.frame_done      = out_frame_done;
  assign result.status          = out_status;
  assign result.data_id         = out_data_id;
  assign result.sequence_number = out_sequence;
  assign result.alive_count     = out_alive;
  assign result.payload_length  = out_length;
  assign result.received_crc    = out_crc;

`ifndef SYNTHESIS
  // Frame state is already clear while a final-byte result waits
  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_frame_done) |-> (byte_count == '0 && crc_reg == CRC_ONES))
    else $error("frame state not cleared after final byte");

  // Status and header fields stay zero on results that do not end a frame
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_frame_done) |->
      (out_status == ST_OK && out_data_id == 16'd0 && out_length == 16'd0
       && out_crc == 32'd0))
    else $error("header fields leaked on a non-final result");

  // An ok frame never declares more payload than allowed
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_frame_done && out_status == ST_OK) |->
      (out_length <= 16'(MAX_PAYLOAD)))
    else $error("ok status with oversized payload");

  // A stalled input register holds its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_data) && $stable(s1_last)))
    else $error("input register lost a stalled item");
`endif

endmodule
